/* design/lex_pkg.sv */
package lex_pkg;

  // input commands
  localparam logic [2:0] CMD_WR_TRANS = 3'd0;
  localparam logic [2:0] CMD_WR_STATE = 3'd1;
  localparam logic [2:0] CMD_WR_CLASS = 3'd2;
  localparam logic [2:0] CMD_CHAR     = 3'd3;
  localparam logic [2:0] CMD_END      = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_TOKEN   = 2'd0;
  localparam logic [1:0] KIND_UNKNOWN = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] START_NL     = 8'd2;
  localparam logic [7:0] START_OTHER  = 8'd1;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [9:0]         index;
    logic [7:0]         verify_state;
    logic [7:0]         next_state;
    logic signed [10:0] base_offset;
    logic [7:0]         fallback_state;
    logic [9:0]         accept_token;
    logic [7:0]         class_code;
    logic [7:0]         char_in;
  } lex_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] token_code;
    logic [6:0] token_length;
    logic [7:0] bad_char;
    logic       last;
  } lex_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_NEXT, S_CLS, S_ST, S_P1, S_P2, S_ACC, S_EMIT, S_RES, S_FIN
  } lex_state_t;

endpackage

/* design/lex_ram.sv */
module lex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* design/lex_seq.sv */
module lex_seq #(
  parameter int TOKEN_MAX   = 64,
  parameter int TRANS_DEPTH = 1024,
  parameter int STATE_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lex_pkg::lex_in_t  in_item,
  input  logic [9:0]        top_index,
  input  logic              out_free,
  output logic              push_v,
  output lex_pkg::lex_res_t push_res
);
  import lex_pkg::*;

  localparam int RW  = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;
  localparam int CW  = $clog2(TOKEN_MAX + 1);
  localparam int TAW = $clog2(TRANS_DEPTH);
  localparam int SAW = $clog2(STATE_COUNT);
  localparam int KW  = $clog2(STATE_COUNT + 1);

  lex_state_t state_r, state_nxt;
  logic [RW-1:0] head_r, head_nxt;
  logic [CW-1:0] bc_r, bc_nxt, avail_r, avail_nxt;
  logic          at_end_r, at_end_nxt;
  logic [7:0]    scan_r, scan_nxt;
  logic [9:0]    best_code_r, best_code_nxt;
  logic [CW-1:0] best_len_r, best_len_nxt;
  logic [7:0]    c_r, c_nxt, s_r, s_nxt;
  logic          fb_r, fb_nxt, neg_r, neg_nxt, sz_r, sz_nxt;
  logic [10:0]   mag_r, mag_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [CW-1:0] take_r, take_nxt;
  logic          tok_r, tok_nxt, fin_r, fin_nxt, pend_v_r, pend_v_nxt;
  lex_res_t      res_r, res_nxt, pend_r, pend_nxt;

  // table memory ports
  logic           tr_we, tr_re, st_we, st_re, cl_we, cl_re, rg_we, rg_re;
  logic [TAW-1:0] tr_waddr, tr_raddr;
  logic [SAW-1:0] st_waddr, st_raddr;
  logic [7:0]     cl_waddr, cl_raddr;
  logic [RW-1:0]  rg_waddr, rg_raddr;
  logic [15:0]    tr_rdata;
  logic [28:0]    st_rdata;
  logic [7:0]     cl_rdata, rg_rdata;

  // shared datapath values
  logic [28:0]        word;
  logic signed [10:0] base;
  logic [11:0]        slot1, slot2;
  logic               ok1, ok2;
  logic               do_fb, do_fail, do_succ, do_emit;
  logic [7:0]         succ_st;
  logic [CW-1:0]      take_v;

  lex_ram #(.WIDTH(16), .DEPTH(TRANS_DEPTH)) u_trans (
    .clk(clk), .we(tr_we), .waddr(tr_waddr),
    .wdata({in_item.verify_state, in_item.next_state}),
    .re(tr_re), .raddr(tr_raddr), .rdata(tr_rdata)
  );
  lex_ram #(.WIDTH(29), .DEPTH(STATE_COUNT)) u_state (
    .clk(clk), .we(st_we), .waddr(st_waddr),
    .wdata({in_item.accept_token, in_item.fallback_state, in_item.base_offset}),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );
  lex_ram #(.WIDTH(8), .DEPTH(256)) u_class (
    .clk(clk), .we(cl_we), .waddr(cl_waddr), .wdata(in_item.class_code),
    .re(cl_re), .raddr(cl_raddr), .rdata(cl_rdata)
  );
  lex_ram #(.WIDTH(8), .DEPTH(TOKEN_MAX)) u_ring (
    .clk(clk), .we(rg_we), .waddr(rg_waddr), .wdata(in_item.char_in),
    .re(rg_re), .raddr(rg_raddr), .rdata(rg_rdata)
  );

  // circular index into the character ring
  function automatic logic [RW-1:0] wrap(input logic [RW-1:0] h, input logic [CW-1:0] j);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(j);
    if (sum >= (CW+1)'(TOKEN_MAX)) begin
      sum = sum - (CW+1)'(TOKEN_MAX);
    end
    return RW'(sum);
  endfunction

  function automatic logic slot_ok(input logic [11:0] sl, input logic [9:0] top);
    return (sl <= {2'b00, top}) && ({20'd0, sl} < 32'(TRANS_DEPTH));
  endfunction

  function automatic logic st_out(input logic [7:0] s);
    return {24'd0, s} >= 32'(STATE_COUNT);
  endfunction

  // probe slots of the current state
  assign word  = sz_r ? '0 : st_rdata;
  assign base  = word[10:0];
  assign slot1 = {1'b0, mag_r} + {4'd0, c_r};
  assign slot2 = {1'b0, mag_r} + {4'd0, cl_rdata};
  assign ok1   = slot_ok(slot1, top_index);
  assign ok2   = slot_ok(slot2, top_index);
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      bc_r        <= '0;
      avail_r     <= '0;
      at_end_r    <= 1'b0;
      scan_r      <= START_NL;
      best_code_r <= '0;
      best_len_r  <= '0;
      pend_v_r    <= 1'b0;
      fin_r       <= 1'b0;
      fb_r        <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      bc_r        <= bc_nxt;
      avail_r     <= avail_nxt;
      at_end_r    <= at_end_nxt;
      scan_r      <= scan_nxt;
      best_code_r <= best_code_nxt;
      best_len_r  <= best_len_nxt;
      pend_v_r    <= pend_v_nxt;
      fin_r       <= fin_nxt;
      fb_r        <= fb_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    s_r    <= s_nxt;
    neg_r  <= neg_nxt;
    sz_r   <= sz_nxt;
    mag_r  <= mag_nxt;
    take_r <= take_nxt;
    tok_r  <= tok_nxt;
    res_r  <= res_nxt;
    pend_r <= pend_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;   head_nxt = head_r;     bc_nxt = bc_r;
    avail_nxt = avail_r;   at_end_nxt = at_end_r;
    scan_nxt = scan_r;     best_code_nxt = best_code_r; best_len_nxt = best_len_r;
    c_nxt = c_r;   s_nxt = s_r;   fb_nxt = fb_r;  neg_nxt = neg_r; sz_nxt = sz_r;
    mag_nxt = mag_r; k_nxt = k_r; take_nxt = take_r; tok_nxt = tok_r;
    fin_nxt = fin_r; pend_v_nxt = pend_v_r; res_nxt = res_r; pend_nxt = pend_r;
    tr_we = 1'b0; tr_re = 1'b0; tr_waddr = TAW'(in_item.index); tr_raddr = TAW'(slot1);
    st_we = 1'b0; st_re = 1'b0; st_waddr = SAW'(in_item.index); st_raddr = SAW'(scan_r);
    cl_we = 1'b0; cl_re = 1'b0; cl_waddr = in_item.index[7:0]; cl_raddr = rg_rdata;
    rg_we = 1'b0; rg_re = 1'b0; rg_waddr = wrap(head_r, bc_r); rg_raddr = wrap(head_r, bc_r);
    push_v = 1'b0; push_res = pend_r;
    do_fb = 1'b0; do_fail = 1'b0; do_succ = 1'b0; do_emit = 1'b0;
    succ_st = tr_rdata[7:0];
    take_v = '0;

    case (state_r)
      // table writes and item start
      S_IDLE: begin
        if (in_valid) begin
          case (in_item.cmd)
            CMD_WR_TRANS: tr_we = ({22'd0, in_item.index} < 32'(TRANS_DEPTH));
            CMD_WR_STATE: st_we = ({22'd0, in_item.index} < 32'(STATE_COUNT));
            CMD_WR_CLASS: cl_we = (in_item.index[9:8] == 2'b00);
            CMD_CHAR: begin
              rg_we      = 1'b1;
              avail_nxt  = bc_r + CW'(1);
              at_end_nxt = 1'b0;
              state_nxt  = S_NEXT;
            end
            CMD_END: begin
              avail_nxt  = bc_r;
              at_end_nxt = 1'b1;
              state_nxt  = S_NEXT;
            end
            default: ;
          endcase
        end
      end
      // top of the scan loop
      S_NEXT: begin
        if (bc_r < avail_r) begin
          rg_re     = 1'b1;
          state_nxt = S_CLS;
        end else if (!at_end_r) begin
          state_nxt = S_FIN;
        end else if (bc_r == '0) begin
          res_nxt   = '{kind: KIND_END, token_code: '0, token_length: '0,
                        bad_char: '0, last: 1'b0};
          fin_nxt   = 1'b1;
          state_nxt = S_RES;
        end else begin
          do_emit = 1'b1;
        end
      end
      // character in hand: fetch its class and the scan state entry
      S_CLS: begin
        c_nxt  = rg_rdata;
        cl_re  = 1'b1;
        st_re  = 1'b1;
        s_nxt  = scan_r;
        sz_nxt = st_out(scan_r);
        fb_nxt = 1'b0;
        k_nxt  = '0;
        mag_nxt = '0;
        state_nxt = S_ST;
      end
      // state entry in hand: first probe
      S_ST: begin
        neg_nxt = base[10];
        mag_nxt = base[10] ? (~base + 11'sd1) : base;
        if (fb_r && base == '0) begin
          do_fail = 1'b1;
        end else if (base == '0) begin
          do_fb = 1'b1;
        end else begin
          state_nxt = S_P1;
          tr_raddr  = TAW'({1'b0, (base[10] ? (~base + 11'sd1) : base)} + {4'd0, c_r});
          tr_re     = slot_ok({1'b0, (base[10] ? (~base + 11'sd1) : base)} + {4'd0, c_r},
                              top_index);
        end
      end
      // direct probe result, then class probe
      S_P1: begin
        if (ok1 && tr_rdata[15:8] == s_r) begin
          do_succ = 1'b1;
        end else if (neg_r && ok2) begin
          tr_re     = 1'b1;
          tr_raddr  = TAW'(slot2);
          state_nxt = S_P2;
        end else begin
          do_fb = 1'b1;
        end
      end
      S_P2: begin
        if (tr_rdata[15:8] == s_r) begin
          do_succ = 1'b1;
        end else begin
          do_fb = 1'b1;
        end
      end
      // accept code of the new state
      S_ACC: begin
        if (word[28:19] != '0) begin
          best_code_nxt = word[28:19];
          best_len_nxt  = bc_r;
        end
        if ({{(32-CW){1'b0}}, bc_r} < TOKEN_MAX) begin
          state_nxt = S_NEXT;
        end else begin
          do_emit = 1'b1;
        end
      end
      // emit from the buffer and rewind for the rescan
      S_EMIT: begin
        if (tok_r) begin
          res_nxt = '{kind: KIND_TOKEN, token_code: best_code_r,
                      token_length: 7'(take_r), bad_char: '0, last: 1'b0};
        end else begin
          res_nxt = '{kind: KIND_UNKNOWN, token_code: '0, token_length: 7'd1,
                      bad_char: rg_rdata, last: 1'b0};
        end
        scan_nxt      = (rg_rdata == NEWLINE_CHAR) ? START_NL : START_OTHER;
        head_nxt      = wrap(head_r, take_r);
        avail_nxt     = avail_r - take_r;
        bc_nxt        = '0;
        best_code_nxt = '0;
        best_len_nxt  = '0;
        fin_nxt       = 1'b0;
        state_nxt     = S_RES;
      end
      // hold one result back so the final one can carry last
      S_RES: begin
        if (!pend_v_r) begin
          pend_nxt   = res_r;
          pend_v_nxt = 1'b1;
          state_nxt  = fin_r ? S_FIN : S_NEXT;
        end else if (out_free) begin
          push_v    = 1'b1;
          pend_nxt  = res_r;
          state_nxt = fin_r ? S_FIN : S_NEXT;
        end
      end
      S_FIN: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push_v        = 1'b1;
          push_res.last = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // follow the default-state chain
    if (do_fb) begin
      if (word[18:11] == '0 || ({1'b0, k_r} + (KW+1)'(1)) == (KW+1)'(STATE_COUNT)) begin
        do_fail = 1'b1;
      end else begin
        s_nxt     = word[18:11];
        sz_nxt    = st_out(word[18:11]);
        st_re     = 1'b1;
        st_raddr  = SAW'(word[18:11]);
        fb_nxt    = 1'b1;
        k_nxt     = k_r + KW'(1);
        state_nxt = S_ST;
      end
    end

    // transition taken
    if (do_succ) begin
      bc_nxt    = bc_r + CW'(1);
      scan_nxt  = succ_st;
      s_nxt     = succ_st;
      sz_nxt    = st_out(succ_st);
      st_re     = 1'b1;
      st_raddr  = SAW'(succ_st);
      state_nxt = S_ACC;
    end

    // no transition
    if (do_fail) begin
      if (bc_r == '0) begin
        res_nxt     = '{kind: KIND_UNKNOWN, token_code: '0, token_length: 7'd1,
                        bad_char: c_r, last: 1'b0};
        scan_nxt    = (c_r == NEWLINE_CHAR) ? START_NL : START_OTHER;
        head_nxt    = wrap(head_r, CW'(1));
        avail_nxt   = avail_r - CW'(1);
        fin_nxt     = 1'b0;
        state_nxt   = S_RES;
      end else begin
        do_emit = 1'b1;
      end
    end

    // read the last character of the emitted piece
    if (do_emit) begin
      take_v    = (best_len_nxt != '0) ? best_len_nxt : CW'(1);
      take_nxt  = take_v;
      tok_nxt   = (best_len_nxt != '0);
      rg_re     = 1'b1;
      rg_raddr  = wrap(head_r, take_v - CW'(1));
      state_nxt = S_EMIT;
    end
  end
endmodule

/* design/table_driven_lexer_scan.sv */
// Table-driven maximal-munch lexer.
// Input channel in_*: one beat per command. in_tuser carries the command: table
// writes (transition, state, class) finish in the accepting cycle and can run back
// to back; a character or end of input starts a scan, and in_tready stays low
// until all of its results are out.
// Result channel out_*: one beat per token, unknown character or end marker;
// out_tlast marks the final result caused by one input beat. Each result leaves
// the scanner when the next one is formed or the scan ends, and shows on
// out_tvalid in the cycle after.
// cfg_wr_en/cfg_wr_data set the highest usable transition slot; write it only
// while the scanner is idle.
// Scan steps: each scanned character takes a ring read, a state and class read,
// the direct probe and an accept read, plus the class probe for a negative base
// and a state read and probe for every default state visited; a result taken
// from the buffer adds a buffer read, an unknown character on an empty buffer
// goes straight out, and a backup rescans the characters after the token. A
// character that only extends the current token holds in_tready low throughout.
// Reset: buffer empty, start state after newline, no best accept; table
// contents are undefined until written.
// Output stall: one result waits in the output register and one more is held
// inside; the scan pauses until out_tready frees the register.
module table_driven_lexer_scan #(
  parameter int TOKEN_MAX   = 64,
  parameter int TRANS_DEPTH = 1024,
  parameter int STATE_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // index, verify_state, next_state, base_offset, fallback_state,
  // accept_token, class_code, char_in
  input  logic [71:0] in_tdata,
  // cmd
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // token_code, token_length, bad_char
  output logic [31:0] out_tdata,
  // kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data
);
  import lex_pkg::*;

  lex_in_t    in_item;
  lex_res_t   push_res, out_r;
  logic       push_v, out_v_r, out_free;
  logic [9:0] top_index_r;

  // unpack the input beat
  assign in_item = '{cmd: in_tuser, index: in_tdata[9:0], verify_state: in_tdata[17:10],
                     next_state: in_tdata[25:18], base_offset: in_tdata[36:26],
                     fallback_state: in_tdata[44:37], accept_token: in_tdata[54:45],
                     class_code: in_tdata[62:55], char_in: in_tdata[70:63]};

  // transition limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_index_r <= '0;
    end else if (cfg_wr_en) begin
      top_index_r <= cfg_wr_data;
    end
  end

  lex_seq #(
    .TOKEN_MAX(TOKEN_MAX), .TRANS_DEPTH(TRANS_DEPTH), .STATE_COUNT(STATE_COUNT)
  ) u_seq (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item(in_item), .top_index(top_index_r), .out_free(out_free),
    .push_v(push_v), .push_res(push_res)
  );

  // output register
  assign out_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push_v) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_v) begin
      out_r <= push_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_r.bad_char, out_r.token_length, out_r.token_code};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
endmodule

/* design/lex_chk.sv */
module lex_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [71:0] in_tdata,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_wr_en,
  input logic [9:0]  cfg_wr_data
);
  import lex_pkg::*;

  // a stalled beat stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");

  // nothing valid right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");

  // end marker is always the final result
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_END |-> out_tlast) else $error("end not last");

  // unknown character has length one
  a_unk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_UNKNOWN |-> out_tdata[16:10] == 7'd1)
    else $error("unknown length");

  // a token consumed at least one character
  a_tok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_TOKEN |-> out_tdata[16:10] != 7'd0)
    else $error("empty token");
endmodule

bind table_driven_lexer_scan lex_chk u_lex_chk (.*);

/* bench/tb_table_driven_lexer_scan.sv */
`timescale 1ns / 100ps

module tb_table_driven_lexer_scan;
  import lex_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [9:0]  cfg_wr_data;

  table_driven_lexer_scan u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // scanner mirror: tables, lookahead and match state
  logic [15:0] trans_mem [0:1023];
  logic [28:0] state_mem [0:255];
  logic [7:0]  class_mem [0:255];
  logic [7:0]  look_mem [0:63];
  int unsigned look_cnt, cur_state, best_code, best_len, prev_char, top_slot;

  lex_res_t    token_q [$];
  int          mismatches;
  int          beats_sent, results_seen, tokens_seen, unknowns_seen, ends_seen;
  int          send_pct, recv_pct;
  int          hold_cnt;

  function automatic logic [28:0] st_word(int unsigned s);
    return (s < 256) ? state_mem[s] : '0;
  endfunction

  function automatic int st_base(int unsigned s);
    logic [28:0]        w;
    logic signed [10:0] b;
    w = st_word(s);
    b = w[10:0];
    return int'(b);
  endfunction

  function automatic int unsigned st_fb(int unsigned s);
    logic [28:0] w;
    w = st_word(s);
    return {24'd0, w[18:11]};
  endfunction

  function automatic int unsigned st_acc(int unsigned s);
    logic [28:0] w;
    w = st_word(s);
    return {22'd0, w[28:19]};
  endfunction

  function automatic int unsigned st_start();
    return (prev_char == NEWLINE_CHAR) ? START_NL : START_OTHER;
  endfunction

  function automatic bit probe_slot(int unsigned slot, int unsigned owner,
                                    output int unsigned nx);
    nx = 0;
    if (slot > top_slot || slot >= 1024) return 0;
    if (trans_mem[slot][15:8] != owner) return 0;
    nx = trans_mem[slot][7:0];
    return 1;
  endfunction

  // follow base/check, class and default-state chain for one character
  function automatic bit step_dfa(int unsigned st, int unsigned c, output int unsigned nx);
    int unsigned s;
    int          b;
    nx = 0;
    s = st;
    for (int k = 0; k < 256; k++) begin
      b = st_base(s);
      if (b > 0) begin
        if (probe_slot(b + c, s, nx)) return 1;
      end else if (b < 0) begin
        if (probe_slot(-b + c, s, nx)) return 1;
        if (probe_slot(-b + class_mem[c], s, nx)) return 1;
      end
      s = st_fb(s);
      if (s == 0 || st_base(s) == 0) return 0;
    end
    return 0;
  endfunction

  // apply one accepted beat to the mirror and collect the results it causes
  task automatic lex_predict(lex_in_t it, output lex_res_t res[$]);
    logic [7:0]  pend [0:64];
    int unsigned qn, qi, c, nx, take, acc;
    bit          at_end;
    lex_res_t    r;
    res = {};
    case (it.cmd)
      CMD_WR_TRANS: trans_mem[it.index] = {it.verify_state, it.next_state};
      CMD_WR_STATE: if (it.index < 256)
        state_mem[it.index] = {it.accept_token, it.fallback_state, it.base_offset};
      CMD_WR_CLASS: if (it.index < 256) class_mem[it.index] = it.class_code;
      default: ;
    endcase
    if (it.cmd != CMD_CHAR && it.cmd != CMD_END) return;
    if (look_cnt >= 64) look_cnt = 63;
    for (int i = 0; i < look_cnt; i++) pend[i] = look_mem[i];
    qn = look_cnt;
    at_end = (it.cmd == CMD_END);
    if (!at_end) begin
      pend[qn] = it.char_in;
      qn++;
    end
    qi = look_cnt;
    forever begin
      r = '0;
      if (qi < qn) begin
        c = pend[qi];
        if (step_dfa(cur_state, c, nx)) begin
          look_mem[look_cnt] = 8'(c);
          look_cnt++;
          qi++;
          cur_state = nx;
          acc = st_acc(nx);
          if (acc != 0) begin
            best_code = acc;
            best_len = look_cnt;
          end
          if (look_cnt < 64) continue;
        end else if (look_cnt == 0) begin
          r.kind = KIND_UNKNOWN; r.token_length = 7'd1; r.bad_char = 8'(c);
          if (res.size() < 64) res.push_back(r);
          prev_char = c;
          qi++;
          cur_state = st_start();
          continue;
        end
      end else begin
        if (!at_end) break;
        if (look_cnt == 0) begin
          r.kind = KIND_END;
          if (res.size() < 64) res.push_back(r);
          break;
        end
      end
      // no way forward: emit the longest match or one unknown character
      r = '0;
      if (best_len > 0 && best_len <= look_cnt) begin
        take = best_len;
        r.kind = KIND_TOKEN; r.token_code = 10'(best_code); r.token_length = 7'(take);
        prev_char = look_mem[take - 1];
      end else begin
        take = 1;
        r.kind = KIND_UNKNOWN; r.token_length = 7'd1; r.bad_char = look_mem[0];
        prev_char = look_mem[0];
      end
      if (res.size() < 64) res.push_back(r);
      qi -= look_cnt - take;
      look_cnt = 0;
      best_code = 0;
      best_len = 0;
      cur_state = st_start();
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
  endtask

  // send one beat, predict on acceptance, then maybe leave a gap
  task automatic send_beat(lex_in_t it, bit use_typed = 0, lex_res_t typed = '0);
    lex_res_t res[$];
    int       gap;
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {1'b0, it.char_in, it.class_code, it.accept_token, it.fallback_state,
                  it.base_offset, it.next_state, it.verify_state, it.index};
    do @(posedge clk); while (!in_tready);
    lex_predict(it, res);
    if (use_typed) res = '{typed};
    foreach (res[i]) token_q.push_back(res[i]);
    beats_sent++;
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every expected result is in and the scanner is idle
  task automatic drain_wait();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (token_q.size() != 0 || !in_tready) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_top(int unsigned v);
    drain_wait();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 10'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    top_slot = v;
    @(posedge clk);
  endtask

  // receiver: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    lex_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind         = out_tuser;
      got.token_code   = out_tdata[9:0];
      got.token_length = out_tdata[16:10];
      got.bad_char     = out_tdata[24:17];
      got.last         = out_tlast;
      results_seen++;
      if (token_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = token_q.pop_front();
        if (got != want || out_tdata[31:25] != 0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
        case (want.kind)
          KIND_TOKEN:   tokens_seen++;
          KIND_UNKNOWN: unknowns_seen++;
          default:      ends_seen++;
        endcase
      end
    end
  end

  // run limit
  initial begin
    #100ms;
    $display("tb_table_driven_lexer_scan: done, errors");
    $finish;
  end

  typedef struct {
    lex_in_t  beat;
    int       reps;
    bit       has_typed;
    lex_res_t typed;
  } stim_row_t;

  function automatic lex_in_t mk(logic [2:0] cmd, int idx = 0, int vs = 0, int ns = 0,
                                 int bo = 0, int fb = 0, int acc = 0, int cc = 0,
                                 int ch = 0);
    lex_in_t it;
    it.cmd = cmd; it.index = 10'(idx); it.verify_state = 8'(vs); it.next_state = 8'(ns);
    it.base_offset = 11'(bo); it.fallback_state = 8'(fb); it.accept_token = 10'(acc);
    it.class_code = 8'(cc); it.char_in = 8'(ch);
    return it;
  endfunction

  // random beats; noisy ones are unused commands with random fields, or table writes out of range
  function automatic lex_in_t rand_beat(bit noisy);
    lex_in_t it;
    int      pick;
    if (noisy) begin
      pick = $urandom_range(3);
      if (pick == 0) begin
        it = mk(CMD_WR_STATE, $urandom_range(256, 1023), 0, 0,
                int'($urandom_range(0, 2047)) - 1024, $urandom_range(0, 255),
                $urandom_range(0, 1023));
      end else if (pick == 1) begin
        it = mk(CMD_WR_CLASS, $urandom_range(256, 1023), 0, 0, 0, 0, 0,
                $urandom_range(0, 255));
      end else begin
        it = mk(3'($urandom_range(5, 7)), $urandom_range(0, 1023), $urandom_range(0, 255),
                $urandom_range(0, 255), int'($urandom_range(0, 2047)) - 1024,
                $urandom_range(0, 255), $urandom_range(0, 1023), $urandom_range(0, 255),
                $urandom_range(0, 255));
      end
      return it;
    end
    pick = $urandom_range(99);
    if (pick < 12) begin
      it = mk(CMD_WR_TRANS, $urandom_range(0, 40), $urandom_range(0, 7), $urandom_range(0, 7));
    end else if (pick < 20) begin
      it = mk(CMD_WR_STATE, $urandom_range(0, 7), 0, 0, int'($urandom_range(0, 24)) - 12,
              ($urandom_range(2) == 0) ? $urandom_range(1, 7) : 0,
              ($urandom_range(1) == 0) ? $urandom_range(1, 1023) : 0);
    end else if (pick < 25) begin
      it = mk(CMD_WR_CLASS, $urandom_range(0, 255), 0, 0, 0, 0, 0, $urandom_range(0, 15));
    end else if (pick < 92) begin
      it = mk(CMD_CHAR, 0, 0, 0, 0, 0, 0, 0, $urandom_range(0, 15));
    end else begin
      it = mk(CMD_END);
    end
    return it;
  endfunction

  initial begin
    stim_row_t rows[$];
    lex_res_t  tr;
    int        tops[4];
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    out_tready = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
    hold_cnt = 0; send_pct = 0; recv_pct = 0; mismatches = 0;
    beats_sent = 0; results_seen = 0; tokens_seen = 0; unknowns_seen = 0; ends_seen = 0;
    look_cnt = 0; prev_char = NEWLINE_CHAR; cur_state = START_NL;
    best_code = 0; best_len = 0; top_slot = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clear the table entries that scans can reach
    for (int i = 0; i < 64; i++) send_beat(mk(CMD_WR_TRANS, i));
    for (int i = 0; i < 16; i++) send_beat(mk(CMD_WR_STATE, i));
    send_beat(mk(CMD_WR_STATE, 255));
    for (int i = 0; i < 16; i++) send_beat(mk(CMD_WR_CLASS, i));
    beats_sent = 0;

    // directed: empty tables at reset top, then a long self-loop token
    tr = '0; tr.kind = KIND_UNKNOWN; tr.token_length = 7'd1; tr.bad_char = 8'd65;
    tr.last = 1;
    rows.push_back('{mk(CMD_CHAR, 0, 0, 0, 0, 0, 0, 0, 65), 1, 1, tr});
    tr.bad_char = 8'd0;
    rows.push_back('{mk(CMD_CHAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, tr});
    tr.bad_char = 8'd255;
    rows.push_back('{mk(CMD_CHAR, 0, 0, 0, 0, 0, 0, 0, 255), 1, 1, tr});
    tr = '0; tr.kind = KIND_END; tr.last = 1;
    rows.push_back('{mk(CMD_END), 1, 1, tr});
    rows.push_back('{mk(3'd5, 1023, 255, 255, -1, 255, 1023, 255, 255), 1, 0, '0});
    rows.push_back('{mk(3'd6), 1, 0, '0});
    rows.push_back('{mk(3'd7), 1, 0, '0});
    rows.push_back('{mk(CMD_WR_STATE, 1023, 0, 0, 1023, 255, 1023), 1, 0, '0});
    rows.push_back('{mk(CMD_WR_CLASS, 1023, 0, 0, 0, 0, 0, 255), 1, 0, '0});
    rows.push_back('{mk(CMD_WR_TRANS, 1023, 255, 255), 1, 0, '0});
    rows.push_back('{mk(CMD_WR_STATE, 3, 0, 0, -1023, 255, 1023), 1, 0, '0});
    rows.push_back('{mk(CMD_WR_STATE, 4, 0, 0, 1023, 0, 0), 1, 0, '0});
    rows.push_back('{mk(CMD_WR_CLASS, 255, 0, 0, 0, 0, 0, 255), 1, 0, '0});
    foreach (rows[i]) repeat (rows[i].reps) send_beat(rows[i].beat, rows[i].has_typed, rows[i].typed);
    rows = {};

    set_top(1023);
    rows.push_back('{mk(CMD_WR_STATE, 1, 0, 0, 2, 0, 0), 1, 0, '0});
    rows.push_back('{mk(CMD_WR_STATE, 2, 0, 0, 1, 0, 5), 1, 0, '0});
    rows.push_back('{mk(CMD_WR_TRANS, 5, 1, 2), 1, 0, '0});
    rows.push_back('{mk(CMD_WR_TRANS, 4, 2, 2), 1, 0, '0});
    rows.push_back('{mk(CMD_CHAR, 0, 0, 0, 0, 0, 0, 0, 3), 70, 0, '0});
    rows.push_back('{mk(CMD_CHAR, 0, 0, 0, 0, 0, 0, 0, 10), 1, 0, '0});
    rows.push_back('{mk(CMD_CHAR, 0, 0, 0, 0, 0, 0, 0, 3), 5, 0, '0});
    rows.push_back('{mk(CMD_END), 1, 0, '0});
    rows.push_back('{mk(CMD_CHAR, 0, 0, 0, 0, 0, 0, 0, 4), 1, 0, '0});
    rows.push_back('{mk(CMD_END), 1, 0, '0});
    foreach (rows[i]) repeat (rows[i].reps) send_beat(rows[i].beat, rows[i].has_typed, rows[i].typed);

    // random phases over several top settings and idling mixes
    tops = '{1023, 0, $urandom_range(8, 40), 1023};
    for (int ph = 0; ph < 4; ph++) begin
      set_top(tops[ph]);
      send_pct = (ph == 0) ? 8 : (ph == 1) ? 80 : 0;
      recv_pct = (ph == 0) ? 80 : (ph == 1) ? 8 : 0;
      if (ph == 2) begin
        @(negedge clk);
        hold_cnt = 400;
      end
      for (int n = 0; n < 42; n++) send_beat(rand_beat($urandom_range(19) == 0));
      send_beat(mk(CMD_END));
    end

    drain_wait();
    $display("sent %0d beats after table clear; results %0d: %0d tokens, %0d unknown, %0d end",
             beats_sent, results_seen, tokens_seen, unknowns_seen, ends_seen);
    $display("covered four top_index settings, full-buffer token, idle mixes and a long stall");
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("tb_table_driven_lexer_scan: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, token_q.size());
      $display("tb_table_driven_lexer_scan: done, errors");
    end
    $finish;
  end

endmodule
